### design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and a helper function of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Default capacity of the bitmap in blocks.
  localparam int DefMaxBlocks = 4096;

  // Field widths of the command and response channels.
  localparam int BlockNumW = 12;
  localparam int StatusW   = 2;
  localparam int TotalW    = 13;

  // One bitmap word covers this many blocks.
  localparam int WordBits = 64;
  localparam int BitIdxW  = 6;

  // Width of a word index derived from a 13-bit block count.
  localparam int ScanW = TotalW - BitIdxW;

  // Configuration port.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegTotalBlocks = 1'b0;
  localparam logic [TotalW-1:0] TotalBlocksReset = 13'd4096;

  // Command codes.
  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } bba_cmd_e;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    StatOk          = 2'd0,
    StatNoSpace     = 2'd1,
    StatAlreadyFree = 2'd2,
    StatOutOfRange  = 2'd3
  } bba_status_e;

  // Index of the lowest set bit of a word, found by halving the search
  // window six times. The result is meaningless for an all-zero word.
  function automatic logic [BitIdxW-1:0] bba_first_set(input logic [WordBits-1:0] v);
    logic [WordBits-1:0] x;
    logic [BitIdxW-1:0]  idx;
    x   = v;
    idx = '0;
    for (int lvl = BitIdxW - 1; lvl >= 0; lvl--) begin
      if ((x & ((64'd1 << (1 << lvl)) - 64'd1)) == 64'd0) begin
        idx[lvl] = 1'b1;
        x        = x >> (1 << lvl);
      end
    end
    return idx;
  endfunction

endpackage

### design/bba_cmd_if.sv
// ----------------------------------------------------------------------------
// bba_cmd_if
// Command channel: allocate or free, with the block number to free.
// ----------------------------------------------------------------------------
interface bba_cmd_if
  import bba_pkg::*;
();
  logic                 valid;
  logic                 ready;
  bba_cmd_e             cmd;
  logic [BlockNumW-1:0] block_number;

  modport source (output valid, output cmd, output block_number, input ready);
  modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

### design/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: allocated block number and status of one command.
// ----------------------------------------------------------------------------
interface bba_rsp_if
  import bba_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BlockNumW-1:0] allocated_block;
  bba_status_e          status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

### design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in block RAM.
// ----------------------------------------------------------------------------
// The bitmap lives in one RAM of 64-bit words, ceil(MAX_BLOCKS/64) deep, with
// registered read data. After reset a clearing pass writes every word to zero,
// one word per cycle; commands wait during this pass while configuration
// writes are taken as usual. Commands are handled one at a time. An allocate
// reads and checks one bitmap word per cycle until it finds a free block,
// scanning at most ceil(count/64) words (64 at a count of 4096). A free is a
// read-modify-write of one word; a free beyond the count and an allocate with
// a zero count are answered without a bitmap access. The next command is
// accepted while a response still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = DefMaxBlocks
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  bba_cmd_if.sink           cmd_i,
  bba_rsp_if.source         rsp_o
);

  localparam int Words = (MAX_BLOCKS + WordBits - 1) / WordBits;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;

  logic [TotalW-1:0]   total_blocks;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [WordBits-1:0] mem_wdata;
  logic                mem_re;
  logic [AddrW-1:0]    mem_raddr;
  logic [WordBits-1:0] mem_rdata;

  // Configuration registers.
  bba_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .total_blocks_o (total_blocks)
  );

  // Bitmap storage.
  bba_bitmap_ram #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Command sequencer.
  bba_engine #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_blocks_i (total_blocks),
    .cmd_i          (cmd_i),
    .rsp_o          (rsp_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

### design/bba_cfg_regs.sv
// ----------------------------------------------------------------------------
// bba_cfg_regs
// APB-style register file holding the managed block count.
// ----------------------------------------------------------------------------
module bba_cfg_regs
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [TotalW-1:0] total_blocks_o
);

  logic [TotalW-1:0] total_blocks_q, total_blocks_d;
  logic              reg_idx;
  logic              wr_en;

  // The register index is the word address above the byte offset.
  assign reg_idx = paddr[PaddrW-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == RegTotalBlocks);

  // Register write.
  always_comb begin
    total_blocks_d = total_blocks_q;
    if (wr_en) begin
      total_blocks_d = pwdata[TotalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= TotalBlocksReset;
    end else begin
      total_blocks_q <= total_blocks_d;
    end
  end

  // Register read; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == RegTotalBlocks) begin
      prdata = {{(PdataW - TotalW){1'b0}}, total_blocks_q};
    end
  end

  assign total_blocks_o = total_blocks_q;

endmodule

### design/bba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Bitmap storage: one 64-bit word per 64 blocks, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_ram
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = DefMaxBlocks,
  localparam int Words = (MAX_BLOCKS + WordBits - 1) / WordBits,
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [WordBits-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [WordBits-1:0] rdata_o
);

  logic [WordBits-1:0] mem [Words];
  logic [WordBits-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bba_engine.sv
// ----------------------------------------------------------------------------
// bba_engine
// Command sequencer: clears the bitmap after reset, scans it word by word
// for the first free block, and performs the read-modify-write of a free.
// ----------------------------------------------------------------------------
module bba_engine
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = DefMaxBlocks,
  localparam int Words = (MAX_BLOCKS + WordBits - 1) / WordBits,
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TotalW-1:0]   total_blocks_i,
  bba_cmd_if.sink             cmd_i,
  bba_rsp_if.source           rsp_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [WordBits-1:0] mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [WordBits-1:0] mem_rdata_i
);

  localparam int MaxCountInt = (MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS;
  localparam logic [TotalW-1:0] MaxCount = TotalW'(MaxCountInt);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Words - 1);

  // Sequencer states.
  localparam logic [2:0] StateClear = 3'd0;
  localparam logic [2:0] StateIdle  = 3'd1;
  localparam logic [2:0] StateScan  = 3'd2;
  localparam logic [2:0] StateFchk  = 3'd3;
  localparam logic [2:0] StateOut   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  logic [ScanW-1:0]     scan_q, scan_d;
  logic [BlockNumW-1:0] blk_q, blk_d;
  logic [BlockNumW-1:0] res_blk_q, res_blk_d;
  bba_status_e          res_st_q, res_st_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [BlockNumW-1:0] rsp_blk_q, rsp_blk_d;
  bba_status_e          rsp_st_q, rsp_st_d;
  logic                 rsp_load;

  logic [TotalW-1:0]    count;
  logic [TotalW-1:0]    count_m1;
  logic [ScanW-1:0]     last_word;
  logic [BitIdxW-1:0]   limit;
  logic [WordBits-1:0]  range_mask;
  logic [WordBits-1:0]  avail;
  logic                 found;
  logic [BitIdxW-1:0]   first;
  logic [TotalW-1:0]    scan_blk;
  logic                 cmd_oor;

  // Managed count, capped at the bitmap capacity and at 8191.
  assign count     = (total_blocks_i > MaxCount) ? MaxCount : total_blocks_i;
  assign count_m1  = count - TotalW'(1);
  assign last_word = count_m1[TotalW-1:BitIdxW];
  assign limit     = count[BitIdxW-1:0];

  // Blocks beyond the count in the last word are treated as used.
  always_comb begin
    range_mask = '1;
    if ((scan_q == last_word) && (limit != '0)) begin
      range_mask = (64'd1 << limit) - 64'd1;
    end
  end

  assign avail    = ~mem_rdata_i & range_mask;
  assign found    = |avail;
  assign first    = bba_first_set(avail);
  assign scan_blk = {scan_q, first};
  assign cmd_oor  = {1'b0, cmd_i.block_number} >= count;

  assign cmd_i.ready = (state_q == StateIdle);

  // Sequencer and memory access. Each command finishes its write-back
  // before the next one can issue a read, so accesses never overlap.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    blk_d       = blk_q;
    res_blk_d   = res_blk_q;
    res_st_d    = res_st_q;
    rsp_load    = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AddrW'(scan_q);
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      StateClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        if (clr_q == LastAddr) begin
          state_d = StateIdle;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      StateIdle: begin
        if (cmd_i.valid) begin
          blk_d     = cmd_i.block_number;
          res_blk_d = '0;
          if (cmd_i.cmd == CmdAlloc) begin
            if (count == '0) begin
              res_st_d = StatNoSpace;
              state_d  = StateOut;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              scan_d      = '0;
              state_d     = StateScan;
            end
          end else if (cmd_oor) begin
            res_st_d = StatOutOfRange;
            state_d  = StateOut;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AddrW'(cmd_i.block_number[BlockNumW-1:BitIdxW]);
            state_d     = StateFchk;
          end
        end
      end
      StateScan: begin
        if (found) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(scan_q);
          mem_wdata_o = mem_rdata_i | (64'd1 << first);
          res_blk_d   = scan_blk[BlockNumW-1:0];
          res_st_d    = StatOk;
          state_d     = StateOut;
        end else if (scan_q == last_word) begin
          res_st_d = StatNoSpace;
          state_d  = StateOut;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(scan_q + ScanW'(1));
          scan_d      = scan_q + ScanW'(1);
        end
      end
      StateFchk: begin
        if (mem_rdata_i[blk_q[BitIdxW-1:0]]) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(blk_q[BlockNumW-1:BitIdxW]);
          mem_wdata_o = mem_rdata_i & ~(64'd1 << blk_q[BitIdxW-1:0]);
          res_st_d    = StatOk;
        end else begin
          res_st_d = StatAlreadyFree;
        end
        state_d = StateOut;
      end
      StateOut: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  // Output register: holds a finished response until it is taken.
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_blk_d   = rsp_blk_q;
    rsp_st_d    = rsp_st_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
      rsp_blk_d   = res_blk_q;
      rsp_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    blk_q     <= blk_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    rsp_blk_q <= rsp_blk_d;
    rsp_st_q  <= rsp_st_d;
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.allocated_block = rsp_blk_q;
  assign rsp_o.status          = rsp_st_q;

  // A read and a write never target the same word in one cycle.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("bitmap read and write hit the same word");

  // No command is taken while the bitmap is being cleared.
  a_no_cmd_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateClear) |-> !cmd_i.ready)
    else $error("command accepted during the clearing pass");

  // The scan never walks past the last managed word.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateScan) |-> (scan_q <= last_word))
    else $error("scan index beyond the managed count");

  // A stalled output keeps the sequencer waiting with its result.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateOut && rsp_valid_q && !rsp_o.ready) |=> (state_q == StateOut))
    else $error("result dropped while the output was stalled");

endmodule
